@@ design/lft_pkg.sv @@
`timescale 1ns / 1ps
// lft_pkg: sizes, codes and shared types of the LRU frame table.
// No dependencies; imported by every module of the block.
package lft_pkg;

    localparam int FRAMES     = 16;
    localparam int STAMP_BITS = 32;
    localparam int FIDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W      = $clog2(FRAMES + 1);

    typedef logic [STAMP_BITS-1:0] stamp_t;
    typedef logic [FIDX_W-1:0]     fidx_t;

    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_TOUCH   = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_EVICTED = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    // one frame entry as held in the table memory
    typedef struct packed {
        logic [7:0] owner;
        logic [7:0] page;
        stamp_t     stamp;
    } entry_t;

    // write request into the table memory
    typedef struct packed {
        logic   tag_en;
        logic   stamp_en;
        fidx_t  addr;
        entry_t data;
    } wr_req_t;

    // result of one step of the age compare unit
    typedef struct packed {
        logic   take;
        stamp_t age;
    } age_res_t;

endpackage

@@ design/lft_frame_mem.sv @@
`timescale 1ns / 1ps
// lft_frame_mem: owner, page and stamp storage for all frames.
// One write port with field enables, one registered read port. Uses lft_pkg.
module lft_frame_mem (
    input  logic             aclk,
    input  lft_pkg::wr_req_t wr,
    input  lft_pkg::fidx_t   rd_addr,
    output lft_pkg::entry_t  rd_data
);
    import lft_pkg::*;

    logic [7:0] owner_mem [FRAMES];
    logic [7:0] page_mem  [FRAMES];
    stamp_t     stamp_mem [FRAMES];

    always_ff @(posedge aclk) begin
        if (wr.tag_en) begin
            owner_mem[wr.addr] <= wr.data.owner;
            page_mem[wr.addr]  <= wr.data.page;
        end
        if (wr.stamp_en) begin
            stamp_mem[wr.addr] <= wr.data.stamp;
        end
        rd_data.owner <= owner_mem[rd_addr];
        rd_data.page  <= page_mem[rd_addr];
        rd_data.stamp <= stamp_mem[rd_addr];
    end

endmodule

@@ design/lft_age_unit.sv @@
`timescale 1ns / 1ps
// lft_age_unit: shared age subtract and compare, one frame per cycle.
// Uses lft_pkg.
module lft_age_unit (
    input  lft_pkg::stamp_t   counter,
    input  lft_pkg::stamp_t   stamp,
    input  logic              valid,
    input  logic              have,
    input  lft_pkg::stamp_t   best_age,
    output lft_pkg::age_res_t res
);
    import lft_pkg::*;

    stamp_t age;

    // modulo difference keeps the ordering right across counter wrap
    assign age      = counter - stamp;
    // strict compare: on equal ages the earlier (lower) frame stays
    assign res.take = valid && (!have || (age > best_age));
    assign res.age  = age;

endmodule

@@ design/lru_frame_table_unit.sv @@
`timescale 1ns / 1ps
// lru_frame_table_unit: LRU frame table, one command per transaction; uses lft_pkg,
// lft_frame_mem and lft_age_unit. A load scans all frames, one per cycle, through the memory
// read port and age unit, then writes (S_SCAN, S_WRITE, S_DONE); touch/release go through
// S_WRITE and S_DONE, an ignored command straight to S_DONE. One command at a time: s_tready
// is high only in S_IDLE, entered as m_tvalid rises; S_DONE waits while the output is full.
// Reset (aresetn low, synchronous): all frames free, stamp counter zero, no result pending.
module lru_frame_table_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // owner_id[7:0], page_no[15:8], frame_index[21:16]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // frame_out[5:0], evict_owner[13:6], evict_page[21:14]
    output logic [1:0]  m_tuser    // status[1:0]
);
    import lft_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_DONE
    } state_t;

    state_t              state_reg;

    // captured command
    logic [1:0]          cmd_reg;
    logic [7:0]          owner_reg;
    logic [7:0]          page_reg;
    logic [5:0]          fidx_reg;

    // frame valid bits and stamp counter
    logic [FRAMES-1:0]   valid_reg;
    stamp_t              counter_reg;

    // scan bookkeeping: issue index and the pending read it produced
    logic [CNT_W-1:0]    iss_reg;
    logic                pend_reg;
    fidx_t               pend_idx_reg;
    logic                free_found_reg;
    fidx_t               free_idx_reg;
    logic                have_reg;
    stamp_t              best_age_reg;
    fidx_t               best_idx_reg;
    logic [7:0]          vic_owner_reg;
    logic [7:0]          vic_page_reg;

    // finished result, waiting for the output register
    logic [1:0]          res_status_reg;
    logic [5:0]          res_frame_reg;
    logic [7:0]          res_owner_reg;
    logic [7:0]          res_page_reg;

    // output register
    logic                m_valid_reg;
    logic [1:0]          m_status_reg;
    logic [5:0]          m_frame_reg;
    logic [7:0]          m_owner_reg;
    logic [7:0]          m_page_reg;

    wr_req_t             wr;
    fidx_t               rd_addr;
    entry_t              rd_data;
    age_res_t            age_res;
    logic                fidx_ok;
    fidx_t               fidx_sel;
    fidx_t               slot;
    logic                issue;
    logic                out_free;

    lft_frame_mem u_mem (
        .aclk    (aclk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    lft_age_unit u_age (
        .counter  (counter_reg),
        .stamp    (rd_data.stamp),
        .valid    (valid_reg[pend_idx_reg]),
        .have     (have_reg),
        .best_age (best_age_reg),
        .res      (age_res)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {2'b00, m_page_reg, m_owner_reg, m_frame_reg};

    assign fidx_ok  = ({1'b0, fidx_reg} < 7'(FRAMES));
    assign fidx_sel = fidx_reg[FIDX_W-1:0];
    assign slot     = free_found_reg ? free_idx_reg : best_idx_reg;
    assign issue    = (state_reg == S_SCAN) && (iss_reg < CNT_W'(FRAMES));
    assign rd_addr  = iss_reg[FIDX_W-1:0];
    assign out_free = !m_valid_reg || m_tready;

    // table write: full entry on load, stamp only on touch
    always_comb begin
        wr            = '0;
        wr.data.owner = owner_reg;
        wr.data.page  = page_reg;
        wr.data.stamp = counter_reg;
        wr.addr       = (cmd_reg == CMD_LOAD) ? slot : fidx_sel;
        if (state_reg == S_WRITE) begin
            case (cmd_reg)
                CMD_LOAD: begin
                    wr.tag_en   = 1'b1;
                    wr.stamp_en = 1'b1;
                end
                CMD_TOUCH: begin
                    wr.stamp_en = 1'b1;
                end
                default: begin
                    wr.stamp_en = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            counter_reg <= '0;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            // drain; a reload in S_DONE takes its place
            if (m_valid_reg && m_tready && (state_reg != S_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        cmd_reg        <= s_tuser;
                        owner_reg      <= s_tdata[7:0];
                        page_reg       <= s_tdata[15:8];
                        fidx_reg       <= s_tdata[21:16];
                        iss_reg        <= '0;
                        pend_reg       <= 1'b0;
                        free_found_reg <= 1'b0;
                        have_reg       <= 1'b0;
                        best_age_reg   <= '0;
                        res_frame_reg  <= s_tdata[21:16];
                        res_owner_reg  <= 8'd0;
                        res_page_reg   <= 8'd0;
                        res_status_reg <= ST_IGNORED;
                        if (s_tuser == CMD_LOAD) begin
                            state_reg <= S_SCAN;
                        end else if (((s_tuser == CMD_TOUCH) || (s_tuser == CMD_RELEASE))
                                     && ({1'b0, s_tdata[21:16]} < 7'(FRAMES))) begin
                            state_reg <= S_WRITE;
                        end else begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_SCAN: begin
                    // read for the next frame goes out while the last one is judged
                    pend_reg     <= issue;
                    pend_idx_reg <= rd_addr;
                    if (issue) begin
                        iss_reg <= iss_reg + CNT_W'(1);
                    end
                    if (pend_reg) begin
                        if (!valid_reg[pend_idx_reg] && !free_found_reg) begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= pend_idx_reg;
                        end
                        if (age_res.take) begin
                            have_reg      <= 1'b1;
                            best_age_reg  <= age_res.age;
                            best_idx_reg  <= pend_idx_reg;
                            vic_owner_reg <= rd_data.owner;
                            vic_page_reg  <= rd_data.page;
                        end
                    end
                    if (!issue) begin
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    case (cmd_reg)
                        CMD_LOAD: begin
                            valid_reg[slot] <= 1'b1;
                            counter_reg     <= counter_reg + 1'b1;
                            res_frame_reg   <= 6'(slot);
                            res_status_reg  <= free_found_reg ? ST_DONE : ST_EVICTED;
                            if (!free_found_reg) begin
                                res_owner_reg <= vic_owner_reg;
                                res_page_reg  <= vic_page_reg;
                            end
                        end
                        CMD_TOUCH: begin
                            res_status_reg <= ST_DONE;
                            counter_reg    <= counter_reg + 1'b1;
                        end
                        default: begin
                            // release; range was checked on accept
                            res_status_reg <= ST_DONE;
                            if (fidx_ok) begin
                                valid_reg[fidx_sel] <= 1'b0;
                            end
                        end
                    endcase
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_frame_reg  <= res_frame_reg;
                        m_owner_reg  <= res_owner_reg;
                        m_page_reg   <= res_page_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
